// ===== design/gbs_pkg.sv =====
// Shared constants and codes of the staggered-grid bilinear sampler.
package gbs_pkg;

   localparam int MAX_COLS_DEF   = 128;
   localparam int MAX_ROWS_DEF   = 128;
   localparam int VALUE_BITS_DEF = 32;

   // item kinds carried in tuser bit 0
   localparam logic ACT_WRITE  = 1'b0;
   localparam logic ACT_SAMPLE = 1'b1;

   // grid codes
   localparam logic [1:0] GRID_CENTER = 2'd0;
   localparam logic [1:0] GRID_U_FACE = 2'd1;
   localparam logic [1:0] GRID_V_FACE = 2'd2;
   localparam logic [1:0] GRID_NONE   = 2'd3;

   // configuration register indexes
   localparam logic [1:0] REG_GRID_WIDTH    = 2'd0;
   localparam logic [1:0] REG_GRID_HEIGHT   = 2'd1;
   localparam logic [1:0] REG_INV_CELL_SIZE = 2'd2;

   localparam logic [7:0]  GRID_WIDTH_RST    = 8'd64;
   localparam logic [7:0]  GRID_HEIGHT_RST   = 8'd64;
   localparam logic [23:0] INV_CELL_SIZE_RST = 24'd65536;

   localparam int FRAC_BITS = 16;
   localparam int HALF_Q16  = 32768;

endpackage

// ===== design/gbs_ram.sv =====
// Generic simple dual-port RAM, one write port, one registered read port.
module gbs_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                       clock,
   input  logic                       wr_en,
   input  logic [$clog2(DEPTH)-1:0]   wr_addr,
   input  logic [WIDTH-1:0]           wr_data,
   input  logic                       rd_en,
   input  logic [$clog2(DEPTH)-1:0]   rd_addr,
   output logic [WIDTH-1:0]           rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/gbs_lerp.sv =====
// Two-stage fixed-point linear blend a*(1-t) + b*t with round half up.
module gbs_lerp
   import gbs_pkg::*;
#(
   parameter int W = 32
) (
   input  logic                clock,
   input  logic                en,
   input  logic signed [W-1:0] a,
   input  logic signed [W-1:0] b,
   input  logic [FRAC_BITS-1:0] t,
   output logic signed [W-1:0] y
);

   localparam int PW = W + FRAC_BITS + 2;
   localparam int SW = PW + 1;

   logic [FRAC_BITS:0]    wa;
   logic signed [PW-1:0]  pa_ff, pa_in;
   logic signed [PW-1:0]  pb_ff, pb_in;
   logic signed [SW-1:0]  sum;
   logic signed [W-1:0]   y_ff, y_in;

   always_comb begin
      wa    = (FRAC_BITS+1)'(1 << FRAC_BITS) - {1'b0, t};
      pa_in = PW'(a * $signed({1'b0, wa}));
      pb_in = PW'(b * $signed({2'b0, t}));
      sum   = SW'(pa_ff) + SW'(pb_ff) + SW'(HALF_Q16);
      // blend stays within the range of its inputs
      y_in  = W'(sum >>> FRAC_BITS);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         pa_ff <= pa_in;
         pb_ff <= pb_in;
         y_ff  <= y_in;
      end
   end

   assign y = y_ff;

endmodule

// ===== design/staggered_grid_bilinear_sampler.sv =====
// Top level of the staggered-grid bilinear sampler.
// Usage:
//  req_*: one item per handshake. tuser bit 0 picks write (0) or sample (1),
//   tuser [2:1] the grid: cell-centred, u faces or v faces. A write loads one
//   entry; a sample returns the bilinear blend of four entries around the
//   scaled position, clamped to the configured grid extent.
//  rsp_*: one item per sample with a valid grid; tdata is the Q16.16 value,
//   tuser the grid tag. Writes and samples of grid code three give nothing.
//  csr_*: register writes (index, data), always ready; write only when idle.
//  Throughput is one item per cycle while rsp_tready is not held low, set by
//   the eight-stage pipeline and by four parity banks per grid that serve the
//   four reads of a sample at once.
//  Reset clears the pipeline valid bits and loads the register defaults; the
//   stores are not cleared and must be written before they are sampled.
//  When the receiver stalls the whole pipeline holds and req_tready falls;
//   nothing is lost or repeated.
module staggered_grid_bilinear_sampler
   import gbs_pkg::*;
#(
   parameter int MAX_COLS   = MAX_COLS_DEF,
   parameter int MAX_ROWS   = MAX_ROWS_DEF,
   parameter int VALUE_BITS = VALUE_BITS_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // write_col, write_row, write_value, pos_x, pos_y
   input  logic [111:0] req_tdata,
   // action, grid_select
   input  logic [2:0]   req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // sample_value
   output logic [31:0]  rsp_tdata,
   // grid_tag
   output logic [1:0]   rsp_tuser,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [1:0]   csr_index,
   input  logic [23:0]  csr_data
);

   localparam int VB   = VALUE_BITS;
   localparam int XW   = $clog2(MAX_COLS + 1);
   localparam int YW   = $clog2(MAX_ROWS + 1);
   localparam int HC   = MAX_COLS / 2 + 1;
   localparam int HR   = MAX_ROWS / 2 + 1;
   localparam int DEPTH = HC * HR;
   localparam int AW   = $clog2(DEPTH);
   localparam int PRW  = 57;
   localparam int SCW  = PRW - FRAC_BITS;
   localparam int IDW  = SCW - FRAC_BITS;
   localparam int WXW  = ((VB > 32) ? VB : 32) + 1;
   localparam logic signed [WXW-1:0] VHI = WXW'((64'sd1 <<< (VB - 1)) - 64'sd1);
   localparam logic signed [WXW-1:0] VLO = -VHI - WXW'(1);
   localparam logic signed [WXW-1:0] OHI = WXW'(64'sd2147483647);
   localparam logic signed [WXW-1:0] OLO = -OHI - WXW'(1);

   logic en;

   // configuration
   logic [7:0]  grid_width_ff, grid_height_ff;
   logic [23:0] inv_cell_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_width_ff  <= GRID_WIDTH_RST;
         grid_height_ff <= GRID_HEIGHT_RST;
         inv_cell_ff    <= INV_CELL_SIZE_RST;
      end else if (csr_valid) begin
         unique case (csr_index)
            REG_GRID_WIDTH:    grid_width_ff  <= csr_data[7:0];
            REG_GRID_HEIGHT:   grid_height_ff <= csr_data[7:0];
            REG_INV_CELL_SIZE: inv_cell_ff    <= csr_data;
            default: ;
         endcase
      end
   end

   // pipeline control
   logic [7:0] smp_ff;
   logic [2:0] wr_ff;
   logic       smp_in, wr_in;

   assign rsp_tvalid = smp_ff[7];
   assign en         = !smp_ff[7] || rsp_tready;
   assign req_tready = en && !reset;
   assign smp_in     = req_tvalid && req_tuser[0] == ACT_SAMPLE && req_tuser[2:1] != GRID_NONE;
   assign wr_in      = req_tvalid && req_tuser[0] == ACT_WRITE;

   always_ff @(posedge clock) begin
      if (reset) begin
         smp_ff <= '0;
         wr_ff  <= '0;
      end else if (en) begin
         smp_ff <= {smp_ff[6:0], smp_in};
         wr_ff  <= {wr_ff[1:0], wr_in};
      end
   end

   // stage 0: input capture
   logic [1:0]         grid0_ff;
   logic [7:0]         col0_ff, row0_ff;
   logic signed [31:0] wval0_ff, px0_ff, py0_ff;

   // stage 1: scaled positions, saturated write value
   logic [1:0]            grid1_ff;
   logic [7:0]            col1_ff, row1_ff;
   logic signed [VB-1:0]  wv1_ff, wv1_in;
   logic signed [PRW-1:0] prx1_ff, pry1_ff;
   logic signed [WXW-1:0] wext;

   always_comb begin
      wext = WXW'(wval0_ff);
      if (wext > VHI) begin
         wv1_in = VB'(VHI);
      end else if (wext < VLO) begin
         wv1_in = VB'(VLO);
      end else begin
         wv1_in = VB'(wext);
      end
   end

   // stage 2: clamped indices and fractions
   logic [1:0]            grid2_ff;
   logic [7:0]            col2_ff, row2_ff;
   logic signed [VB-1:0]  wv2_ff;
   logic [XW-1:0]         ix2_ff, ix12_ff, ix_in, ix1_in, nx, lim_x;
   logic [YW-1:0]         iy2_ff, iy12_ff, iy_in, iy1_in, ny, lim_y;
   logic [FRAC_BITS-1:0]  tx2_ff, ty2_ff, tx_in, ty_in;
   logic signed [SCW-1:0] sx, sy;
   logic signed [IDW-1:0] idx_x, idx_y;

   always_comb begin
      if (grid_width_ff == 8'd0) begin
         nx = XW'(1);
      end else if (int'(grid_width_ff) > MAX_COLS) begin
         nx = XW'(MAX_COLS);
      end else begin
         nx = XW'(grid_width_ff);
      end
      if (grid_height_ff == 8'd0) begin
         ny = YW'(1);
      end else if (int'(grid_height_ff) > MAX_ROWS) begin
         ny = YW'(MAX_ROWS);
      end else begin
         ny = YW'(grid_height_ff);
      end
      lim_x = (grid1_ff == GRID_U_FACE) ? nx : nx - XW'(1);
      lim_y = (grid1_ff == GRID_V_FACE) ? ny : ny - YW'(1);

      // half-cell offset on each axis but the face axis of a face grid
      sx = SCW'(prx1_ff >>> FRAC_BITS);
      sy = SCW'(pry1_ff >>> FRAC_BITS);
      if (grid1_ff != GRID_U_FACE) begin
         sx = sx - SCW'(HALF_Q16);
      end
      if (grid1_ff != GRID_V_FACE) begin
         sy = sy - SCW'(HALF_Q16);
      end
      idx_x = sx[SCW-1:FRAC_BITS];
      idx_y = sy[SCW-1:FRAC_BITS];
      tx_in = sx[FRAC_BITS-1:0];
      ty_in = sy[FRAC_BITS-1:0];

      if (idx_x < 0) begin
         ix_in = '0;
      end else if (idx_x > $signed(IDW'(lim_x))) begin
         ix_in = lim_x;
      end else begin
         ix_in = XW'(idx_x);
      end
      if (idx_y < 0) begin
         iy_in = '0;
      end else if (idx_y > $signed(IDW'(lim_y))) begin
         iy_in = lim_y;
      end else begin
         iy_in = YW'(idx_y);
      end
      ix1_in = (ix_in == lim_x) ? lim_x : ix_in + XW'(1);
      iy1_in = (iy_in == lim_y) ? lim_y : iy_in + YW'(1);
   end

   // stage 3: parity-banked store access
   logic [1:0]           grid3_ff;
   logic                 ixp3_ff, ix1p3_ff, iyp3_ff, iy1p3_ff;
   logic [FRAC_BITS-1:0] tx3_ff, ty3_ff;
   logic [AW-1:0]        rd_addr [4];
   logic [AW-1:0]        wr_addr;
   logic [1:0]           wr_bank;
   logic                 wr_ok;
   logic [XW-1:0]        bcol [4];
   logic [YW-1:0]        brow [4];
   logic [XW-1:0]        wcol;
   logic [YW-1:0]        wrow;

   always_comb begin
      for (int b = 0; b < 4; b++) begin
         bcol[b] = (ix2_ff[0] == b[0]) ? ix2_ff : ix12_ff;
         brow[b] = (iy2_ff[0] == b[1]) ? iy2_ff : iy12_ff;
         rd_addr[b] = AW'(AW'(brow[b] >> 1) * AW'(HC) + AW'(bcol[b] >> 1));
      end
      wcol    = XW'(col2_ff);
      wrow    = YW'(row2_ff);
      wr_addr = AW'(AW'(wrow >> 1) * AW'(HC) + AW'(wcol >> 1));
      wr_bank = {row2_ff[0], col2_ff[0]};
      unique case (grid2_ff)
         GRID_CENTER: wr_ok = int'(col2_ff) < MAX_COLS && int'(row2_ff) < MAX_ROWS;
         GRID_U_FACE: wr_ok = int'(col2_ff) <= MAX_COLS && int'(row2_ff) < MAX_ROWS;
         GRID_V_FACE: wr_ok = int'(col2_ff) < MAX_COLS && int'(row2_ff) <= MAX_ROWS;
         default:     wr_ok = 1'b0;
      endcase
   end

   logic [VB-1:0] rd_data [3][4];

   for (genvar g = 0; g < 3; g++) begin : g_grid
      for (genvar b = 0; b < 4; b++) begin : g_bank
         gbs_ram #(
            .WIDTH (VB),
            .DEPTH (DEPTH)
         ) u_ram (
            .clock   (clock),
            .wr_en   (en && wr_ff[2] && wr_ok && grid2_ff == 2'(g) && wr_bank == 2'(b)),
            .wr_addr (wr_addr),
            .wr_data (wv2_ff),
            .rd_en   (en),
            .rd_addr (rd_addr[b]),
            .rd_data (rd_data[g][b])
         );
      end
   end

   // stage 4 input: corner selection
   logic [VB-1:0]        bank_q [4];
   logic signed [VB-1:0] ea, eb, ec, ed;

   always_comb begin
      for (int b = 0; b < 4; b++) begin
         unique case (grid3_ff)
            GRID_U_FACE: bank_q[b] = rd_data[1][b];
            GRID_V_FACE: bank_q[b] = rd_data[2][b];
            default:     bank_q[b] = rd_data[0][b];
         endcase
      end
      ea = bank_q[{iyp3_ff, ixp3_ff}];
      eb = bank_q[{iyp3_ff, ix1p3_ff}];
      ec = bank_q[{iy1p3_ff, ixp3_ff}];
      ed = bank_q[{iy1p3_ff, ix1p3_ff}];
   end

   // stages 4..7: blends
   logic [1:0]           grid4_ff, grid5_ff, grid6_ff, grid7_ff;
   logic [FRAC_BITS-1:0] ty4_ff, ty5_ff;
   logic signed [VB-1:0] ab, cd, res;

   gbs_lerp #(.W (VB)) u_lerp_ab (
      .clock (clock), .en (en), .a (ea), .b (eb), .t (tx3_ff), .y (ab)
   );
   gbs_lerp #(.W (VB)) u_lerp_cd (
      .clock (clock), .en (en), .a (ec), .b (ed), .t (tx3_ff), .y (cd)
   );
   gbs_lerp #(.W (VB)) u_lerp_y (
      .clock (clock), .en (en), .a (ab), .b (cd), .t (ty5_ff), .y (res)
   );

   always_ff @(posedge clock) begin
      if (en) begin
         grid0_ff <= req_tuser[2:1];
         col0_ff  <= req_tdata[7:0];
         row0_ff  <= req_tdata[15:8];
         wval0_ff <= req_tdata[47:16];
         px0_ff   <= req_tdata[79:48];
         py0_ff   <= req_tdata[111:80];

         grid1_ff <= grid0_ff;
         col1_ff  <= col0_ff;
         row1_ff  <= row0_ff;
         wv1_ff   <= wv1_in;
         prx1_ff  <= PRW'(px0_ff * $signed({1'b0, inv_cell_ff}));
         pry1_ff  <= PRW'(py0_ff * $signed({1'b0, inv_cell_ff}));

         grid2_ff <= grid1_ff;
         col2_ff  <= col1_ff;
         row2_ff  <= row1_ff;
         wv2_ff   <= wv1_ff;
         ix2_ff   <= ix_in;
         ix12_ff  <= ix1_in;
         iy2_ff   <= iy_in;
         iy12_ff  <= iy1_in;
         tx2_ff   <= tx_in;
         ty2_ff   <= ty_in;

         grid3_ff <= grid2_ff;
         ixp3_ff  <= ix2_ff[0];
         ix1p3_ff <= ix12_ff[0];
         iyp3_ff  <= iy2_ff[0];
         iy1p3_ff <= iy12_ff[0];
         tx3_ff   <= tx2_ff;
         ty3_ff   <= ty2_ff;

         grid4_ff <= grid3_ff;
         ty4_ff   <= ty3_ff;
         grid5_ff <= grid4_ff;
         ty5_ff   <= ty4_ff;
         grid6_ff <= grid5_ff;
         grid7_ff <= grid6_ff;
      end
   end

   // output saturation to 32 bits
   logic signed [WXW-1:0] rext;

   always_comb begin
      rext = WXW'(res);
      if (rext > OHI) begin
         rsp_tdata = 32'(OHI);
      end else if (rext < OLO) begin
         rsp_tdata = 32'(OLO);
      end else begin
         rsp_tdata = 32'(rext);
      end
   end

   assign rsp_tuser = grid7_ff;

   // a stage holds either a write or a sample, never both
   a_kind_excl: assert property (@(posedge clock) disable iff (reset)
      !(wr_ff[2] && smp_ff[2]))
      else $error("write and sample share a stage");

   // clamped neighbour is the index itself or one above it
   a_ix1_step: assert property (@(posedge clock) disable iff (reset)
      smp_ff[2] |-> (ix12_ff == ix2_ff || ix12_ff == ix2_ff + XW'(1)))
      else $error("x neighbour out of step");

   a_iy1_step: assert property (@(posedge clock) disable iff (reset)
      smp_ff[2] |-> (iy12_ff == iy2_ff || iy12_ff == iy2_ff + YW'(1)))
      else $error("y neighbour out of step");

   // stalled pipeline keeps its occupancy
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      !en |=> $stable(smp_ff) && $stable(wr_ff))
      else $error("pipeline moved during stall");

   a_tag_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tuser != GRID_NONE)
      else $error("result for grid code three");

endmodule

// ===== dv/staggered_grid_bilinear_sampler_tb.sv =====
// Self-checking testbench for the staggered-grid bilinear sampler.
`timescale 1ns / 1ps

module staggered_grid_bilinear_sampler_tb;
   import gbs_pkg::*;

   localparam int  NCOL       = MAX_COLS_DEF;
   localparam int  NROW       = MAX_ROWS_DEF;
   localparam int  DRAIN_WAIT = 24;
   localparam longint CYCLE_LIMIT = 3000000;

   typedef struct {
      logic        act;
      logic [1:0]  grid;
      logic [7:0]  col;
      logic [7:0]  row;
      logic [31:0] val;
      logic [31:0] px;
      logic [31:0] py;
      bit          typed;
      logic [31:0] typed_val;
   } grid_item_type;

   typedef struct {
      logic [31:0] value;
      logic [1:0]  tag;
   } sample_type;

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [111:0] req_tdata;
   logic [2:0]   req_tuser;
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [31:0]  rsp_tdata;
   logic [1:0]   rsp_tuser;
   logic         csr_valid;
   logic         csr_ready;
   logic [1:0]   csr_index;
   logic [23:0]  csr_data;

   staggered_grid_bilinear_sampler dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      clock = 1'b1;
      #2;
      clock = 1'b0;
      #2;
   end

   // mirror of the block's stores and registers
   logic signed [31:0] centre_mem [NROW][NCOL];
   logic signed [31:0] u_mem      [NROW][NCOL+1];
   logic signed [31:0] v_mem      [NROW+1][NCOL];
   logic [7:0]         cfg_width;
   logic [7:0]         cfg_height;
   logic [23:0]        cfg_inv;

   sample_type pending_samples[$];
   int      errors;
   int      samples_seen;
   int      items_sent;
   int      burst_left;
   longint  cycles = 0;

   task automatic report(input string msg);
      $display("mismatch @%0d: %s", cycles, msg);
      errors++;
   endtask

   function automatic longint entry(input logic [1:0] grid, input longint col,
                                    input longint row);
      if (grid == GRID_CENTER) return longint'(centre_mem[row][col]);
      if (grid == GRID_U_FACE) return longint'(u_mem[row][col]);
      return longint'(v_mem[row][col]);
   endfunction

   function automatic longint mix(input longint a, input longint b, input longint t);
      return (a * (65536 - t) + b * t + HALF_Q16) >>> FRAC_BITS;
   endfunction

   function automatic longint clamp(input longint v, input longint lim);
      if (v < 0) return 0;
      if (v > lim) return lim;
      return v;
   endfunction

   // scaled position to floor index plus fraction; fraction taken before clamping
   task automatic split_axis(input logic [31:0] pos, input bit stagger,
                             output longint idx, output longint frac);
      longint s;
      s = (longint'(signed'(pos)) * longint'(cfg_inv)) >>> FRAC_BITS;
      if (stagger) s -= HALF_Q16;
      idx  = s >>> FRAC_BITS;
      frac = s - idx * 65536;
   endtask

   task automatic bilinear_sample(input logic [1:0] grid, input logic [31:0] px,
                                  input logic [31:0] py, output logic [31:0] res);
      longint nx, ny, lx, ly, ix, iy, tx, ty, ix1, iy1, ab, cd, r;
      nx = (cfg_width == 0) ? 1 : ((cfg_width > NCOL) ? NCOL : cfg_width);
      ny = (cfg_height == 0) ? 1 : ((cfg_height > NROW) ? NROW : cfg_height);
      lx = (grid == GRID_U_FACE) ? nx : nx - 1;
      ly = (grid == GRID_V_FACE) ? ny : ny - 1;
      split_axis(px, grid != GRID_U_FACE, ix, tx);
      split_axis(py, grid != GRID_V_FACE, iy, ty);
      ix  = clamp(ix, lx);
      iy  = clamp(iy, ly);
      ix1 = (ix + 1 > lx) ? lx : ix + 1;
      iy1 = (iy + 1 > ly) ? ly : iy + 1;
      ab = mix(entry(grid, ix, iy), entry(grid, ix1, iy), tx);
      cd = mix(entry(grid, ix, iy1), entry(grid, ix1, iy1), tx);
      r  = mix(ab, cd, ty);
      if (r > 64'sh7FFFFFFF) r = 64'sh7FFFFFFF;
      if (r < -64'sh80000000) r = -64'sh80000000;
      res = r[31:0];
   endtask

   // bookkeeping for an item the block has taken
   task automatic take_item(input grid_item_type it);
      sample_type s;
      if (it.grid == GRID_NONE) return;
      if (it.act == ACT_WRITE) begin
         if (it.grid == GRID_CENTER && it.col < NCOL && it.row < NROW)
            centre_mem[it.row][it.col] = it.val;
         else if (it.grid == GRID_U_FACE && it.col <= NCOL && it.row < NROW)
            u_mem[it.row][it.col] = it.val;
         else if (it.grid == GRID_V_FACE && it.col < NCOL && it.row <= NROW)
            v_mem[it.row][it.col] = it.val;
         return;
      end
      s.tag = it.grid;
      if (it.typed) s.value = it.typed_val;
      else bilinear_sample(it.grid, it.px, it.py, s.value);
      pending_samples.push_back(s);
   endtask

   task automatic send_item(input grid_item_type it);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         burst_left = $urandom_range(1, 24);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tdata  <= {it.py, it.px, it.val, it.row, it.col};
      req_tuser  <= {it.grid, it.act};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      take_item(it);
      items_sent++;
   endtask

   // let the pipeline empty; writes leave nothing behind to wait on, hence the tail
   task automatic drain();
      req_tvalid <= 1'b0;
      while (pending_samples.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
   endtask

   task automatic set_config(input logic [7:0] w, input logic [7:0] h,
                             input logic [23:0] inv);
      logic [23:0] vals [3];
      logic [1:0]  idx [3];
      vals = '{{16'd0, w}, {16'd0, h}, inv};
      idx  = '{REG_GRID_WIDTH, REG_GRID_HEIGHT, REG_INV_CELL_SIZE};
      for (int i = 0; i < 3; i++) begin
         csr_valid <= 1'b1;
         csr_index <= idx[i];
         csr_data  <= vals[i];
         @(posedge clock);
         while (!csr_ready) @(posedge clock);
      end
      csr_valid <= 1'b0;
      cfg_width  = w;
      cfg_height = h;
      cfg_inv    = inv;
   endtask

   function automatic grid_item_type mk(input logic act, input logic [1:0] grid,
                                     input logic [7:0] col, input logic [7:0] row,
                                     input logic [31:0] val, input logic [31:0] px,
                                     input logic [31:0] py, input bit typed = 0,
                                     input logic [31:0] tv = 0);
      grid_item_type it;
      it.act = act; it.grid = grid; it.col = col; it.row = row; it.val = val;
      it.px = px; it.py = py; it.typed = typed; it.typed_val = tv;
      return it;
   endfunction

   function automatic grid_item_type random_item();
      logic [1:0]  grid;
      longint      span, cc, cr, wx, wy;
      grid_item_type it;
      grid = ($urandom_range(0, 99) < 3) ? GRID_NONE : 2'($urandom_range(0, 2));
      if ($urandom_range(0, 3) == 0) begin
         // writes, now and then beyond the store
         if ($urandom_range(0, 9) == 0)
            return mk(ACT_WRITE, grid, 8'($urandom), 8'($urandom), $urandom, $urandom,
                      $urandom);
         return mk(ACT_WRITE, grid, 8'($urandom_range(0, NCOL - (grid == GRID_U_FACE ? 0 : 1))),
                   8'($urandom_range(0, NROW - (grid == GRID_V_FACE ? 0 : 1))),
                   $urandom, $urandom, $urandom);
      end
      if (cfg_inv == 0 || $urandom_range(0, 6) == 0)
         return mk(ACT_SAMPLE, grid, 8'($urandom), 8'($urandom), $urandom, $urandom,
                   $urandom);
      // aim near the configured grid, in cell units, then back to world units
      span = longint'(cfg_width > cfg_height ? cfg_width : cfg_height) + 4;
      cc = longint'($urandom_range(0, 32'(span * 65536))) - 2 * 65536;
      cr = longint'($urandom_range(0, 32'(span * 65536))) - 2 * 65536;
      wx = (cc * 65536) / longint'(cfg_inv);
      wy = (cr * 65536) / longint'(cfg_inv);
      wx = (wx > 64'sh7FFFFFFF) ? 64'sh7FFFFFFF : wx;
      wy = (wy > 64'sh7FFFFFFF) ? 64'sh7FFFFFFF : wy;
      wx = (wx < -64'sh80000000) ? -64'sh80000000 : wx;
      wy = (wy < -64'sh80000000) ? -64'sh80000000 : wy;
      it = mk(ACT_SAMPLE, grid, 8'($urandom), 8'($urandom), $urandom, wx[31:0], wy[31:0]);
      return it;
   endfunction

   // result side: stall pattern changes mode every so often
   int ready_mode = 0;
   always @(posedge clock) begin
      if (cycles % 128 == 0) ready_mode <= $urandom_range(0, 2);
      case (ready_mode)
         0: rsp_tready <= 1'b1;
         1: rsp_tready <= ($urandom_range(0, 9) < 7);
         default: rsp_tready <= ($urandom_range(0, 3) == 0);
      endcase
   end

   always @(posedge clock) begin
      sample_type exp_s;
      if (!reset && rsp_tvalid && rsp_tready) begin
         samples_seen++;
         if (pending_samples.size() == 0) begin
            report($sformatf("unexpected sample %h tag %0d", rsp_tdata, rsp_tuser));
         end else begin
            exp_s = pending_samples.pop_front();
            if (rsp_tdata !== exp_s.value)
               report($sformatf("value %h, wanted %h", rsp_tdata, exp_s.value));
            if (rsp_tuser !== exp_s.tag)
               report($sformatf("tag %0d, wanted %0d", rsp_tuser, exp_s.tag));
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("FAIL");
         $finish;
      end
   end

   initial begin
      grid_item_type dir_rows[$];
      logic [7:0]  rw, rh;
      logic [23:0] ri;
      errors = 0; samples_seen = 0; items_sent = 0; burst_left = 0;
      reset = 1'b1;
      req_tvalid = 1'b0; req_tdata = '0; req_tuser = '0;
      csr_valid = 1'b0; csr_index = '0; csr_data = '0;
      cfg_width = GRID_WIDTH_RST; cfg_height = GRID_HEIGHT_RST; cfg_inv = INV_CELL_SIZE_RST;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // stores are not cleared by reset: fill every entry before any sample
      for (int r = 0; r < NROW; r++)
         for (int c = 0; c < NCOL; c++)
            send_item(mk(ACT_WRITE, GRID_CENTER, 8'(c), 8'(r), $urandom, 0, 0));
      for (int r = 0; r < NROW; r++)
         for (int c = 0; c <= NCOL; c++)
            send_item(mk(ACT_WRITE, GRID_U_FACE, 8'(c), 8'(r), $urandom, 0, 0));
      for (int r = 0; r <= NROW; r++)
         for (int c = 0; c < NCOL; c++)
            send_item(mk(ACT_WRITE, GRID_V_FACE, 8'(c), 8'(r), $urandom, 0, 0));
      items_sent = 0;

      // directed part, register defaults
      dir_rows.push_back(mk(ACT_WRITE, GRID_CENTER, 0, 0, 32'h7FFFFFFF, 0, 0));
      dir_rows.push_back(mk(ACT_WRITE, GRID_CENTER, 1, 0, 32'h7FFFFFFF, 0, 0));
      dir_rows.push_back(mk(ACT_WRITE, GRID_CENTER, 0, 1, 32'h7FFFFFFF, 0, 0));
      dir_rows.push_back(mk(ACT_WRITE, GRID_CENTER, 1, 1, 32'h7FFFFFFF, 0, 0));
      dir_rows.push_back(mk(ACT_SAMPLE, GRID_CENTER, 0, 0, 0, 32'h80000000, 32'h80000000,
                            1, 32'h7FFFFFFF));
      dir_rows.push_back(mk(ACT_WRITE, GRID_U_FACE, 0, 0, 32'h80000000, 0, 0));
      dir_rows.push_back(mk(ACT_WRITE, GRID_U_FACE, 1, 0, 32'h80000000, 0, 0));
      dir_rows.push_back(mk(ACT_WRITE, GRID_U_FACE, 0, 1, 32'h80000000, 0, 0));
      dir_rows.push_back(mk(ACT_WRITE, GRID_U_FACE, 1, 1, 32'h80000000, 0, 0));
      dir_rows.push_back(mk(ACT_SAMPLE, GRID_U_FACE, 0, 0, 0, 32'h80000000, 32'h80000000,
                            1, 32'h80000000));
      dir_rows.push_back(mk(ACT_SAMPLE, GRID_V_FACE, 8'hFF, 8'hFF, 32'hFFFFFFFF,
                            32'h7FFFFFFF, 32'h7FFFFFFF));
      // writes beyond each store are dropped; last legal face entries kept
      dir_rows.push_back(mk(ACT_WRITE, GRID_CENTER, 128, 0, 32'h11111111, 0, 0));
      dir_rows.push_back(mk(ACT_WRITE, GRID_U_FACE, 129, 0, 32'h22222222, 0, 0));
      dir_rows.push_back(mk(ACT_WRITE, GRID_V_FACE, 0, 129, 32'h33333333, 0, 0));
      dir_rows.push_back(mk(ACT_WRITE, GRID_U_FACE, 128, 127, 32'h44444444, 0, 0));
      dir_rows.push_back(mk(ACT_WRITE, GRID_V_FACE, 127, 128, 32'h55555555, 0, 0));
      dir_rows.push_back(mk(ACT_WRITE, GRID_CENTER, 255, 255, 32'h66666666, 0, 0));
      dir_rows.push_back(mk(ACT_WRITE, GRID_NONE, 3, 3, 32'h77777777, 0, 0));
      dir_rows.push_back(mk(ACT_SAMPLE, GRID_NONE, 0, 0, 0, 32'h00018000, 32'h00018000));
      dir_rows.push_back(mk(ACT_SAMPLE, GRID_CENTER, 0, 0, 0, 0, 0));
      dir_rows.push_back(mk(ACT_SAMPLE, GRID_U_FACE, 0, 0, 0, 32'h003FFFFF, 32'h003F0000));
      dir_rows.push_back(mk(ACT_SAMPLE, GRID_V_FACE, 0, 0, 0, 32'h003F8000, 32'h00400000));
      dir_rows.push_back(mk(ACT_SAMPLE, GRID_CENTER, 0, 0, 0, 32'h00018000, 32'h00024000));
      foreach (dir_rows[i]) send_item(dir_rows[i]);
      drain();

      // random phases over register settings, extremes first
      for (int ph = 0; ph < 7; ph++) begin
         case (ph)
            0: begin rw = 8'd64;  rh = 8'd64;  ri = 24'd65536;   end
            1: begin rw = 8'd1;   rh = 8'd1;   ri = 24'd1;       end
            2: begin rw = 8'd128; rh = 8'd128; ri = 24'hFFFFFF;  end
            3: begin rw = 8'd0;   rh = 8'd255; ri = 24'd0;       end
            4: begin rw = 8'd200; rh = 8'd0;   ri = 24'd40000;   end
            default: begin
               rw = 8'($urandom_range(0, 255));
               rh = 8'($urandom_range(0, 255));
               ri = 24'($urandom_range(1, 24'h3FFFFF));
            end
         endcase
         set_config(rw, rh, ri);
         repeat (145) send_item(random_item());
         drain();
      end

      $display("covered %0d items over 7 register settings, %0d samples returned",
               items_sent, samples_seen);
      $display("all three grids, writes beyond the stores, grid code three, clamped sizes");
      if (pending_samples.size() != 0)
         report($sformatf("%0d samples never returned", pending_samples.size()));
      if (errors == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
